>>> hdl/rrp_pkg.sv
// rrp_pkg: shared constants, types and helpers for the rectangle raster painter
// depends on nothing; used by every module of the painter except rrp_ram
package rrp_pkg;

   localparam int MAX_SIDE  = 256;
   localparam int FRAC_BITS = 8;

   localparam int SIDE_W  = $clog2(MAX_SIDE);
   localparam int ADDR_W  = 2 * SIDE_W;
   localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
   localparam int CFG_W   = 9;
   localparam int CHAR_W  = 8;
   localparam int COORD_W = 20;
   localparam int POS_W   = ((COORD_W > SIDE_W + FRAC_BITS) ? COORD_W : SIDE_W + FRAC_BITS) + 2;
   localparam int RC_W    = 8;
   localparam int IDX_W   = 2;

   localparam logic [CHAR_W-1:0] TYPE_FILLED  = 8'h52;
   localparam logic [CHAR_W-1:0] TYPE_OUTLINE = 8'h72;
   localparam logic [CHAR_W-1:0] BG_RESET     = 8'h20;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_DRAW  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [IDX_W-1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_BG     = 2'd2,
      REG_UNUSED = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic step;
      logic capture;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic draw_go;
      logic sweep_done;
      logic rsp_busy;
   } dp_status_type;

   function automatic logic [CFG_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (32'(v) > MAX_SIDE) begin
         r = CFG_W'(MAX_SIDE);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

>>> hdl/rrp_ram.sv
// rrp_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module rrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/rrp_ctrl.sv
// rrp_ctrl: sequencing state machine of the painter
// depends on rrp_pkg; drives the datapath through dp_cmd_type
module rrp_ctrl
   import rrp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_operation,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          req_stall
);

   state_type state_ff, state_in;
   op_type    op;

   assign op = op_type'(req_operation);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (op)
                  OP_CLEAR: state_in = ST_SWEEP;
                  OP_DRAW:  state_in = status.draw_go ? ST_SWEEP : ST_DONE;
                  OP_READ:  state_in = ST_READ;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_SWEEP: begin
            if (status.sweep_done) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_SWEEP: cmd.step     = 1'b1;
         ST_READ:  cmd.capture  = 1'b1;
         ST_DONE:  cmd.load_rsp = !status.rsp_busy;
         default:  cmd          = '0;
      endcase
   end

endmodule

>>> hdl/rrp_dp.sv
// rrp_dp: datapath with config registers, pixel sweep counters, coverage test,
// canvas memory and result register; depends on rrp_pkg and rrp_ram
module rrp_dp
   import rrp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  logic                     csr_valid,
   input  logic [IDX_W-1:0]         csr_index,
   input  logic [CFG_W-1:0]         csr_data,
   input  logic [1:0]               req_operation,
   input  logic [CHAR_W-1:0]        req_rect_type,
   input  logic signed [COORD_W-1:0] req_rect_x,
   input  logic signed [COORD_W-1:0] req_rect_y,
   input  logic signed [COORD_W-1:0] req_rect_width,
   input  logic signed [COORD_W-1:0] req_rect_height,
   input  logic [CHAR_W-1:0]        req_rect_char,
   input  logic [RC_W-1:0]          req_read_row,
   input  logic [RC_W-1:0]          req_read_col,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic [CHAR_W-1:0]        rsp_pixel_value,
   output logic                     rsp_corrupted
);

   localparam logic signed [POS_W-1:0] ONE = POS_W'(1) << FRAC_BITS;

   logic [CFG_W-1:0]  width_ff, height_ff;
   logic [CHAR_W-1:0] bg_ff;
   logic              err_ff, clear_ff, filled_ff, in_range_ff;
   logic [CHAR_W-1:0] char_ff, pix_ff;
   logic signed [POS_W-1:0] x_ff, y_ff, xend_ff, yend_ff;
   logic [SIDE_W-1:0] row_ff, col_ff, lim_row_ff, lim_col_ff;
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] rsp_pixel_ff;
   logic              rsp_corrupted_ff;

   op_type            op;
   reg_index_type     ridx;
   logic              bad, covered, edge_hit, we;
   logic signed [POS_W-1:0] pi, pj, sx, sy, sw, sh;
   logic [CHAR_W-1:0] rdata;

   assign op   = op_type'(req_operation);
   assign ridx = reg_index_type'(csr_index);

   assign sx = POS_W'(req_rect_x);
   assign sy = POS_W'(req_rect_y);
   assign sw = POS_W'(req_rect_width);
   assign sh = POS_W'(req_rect_height);

   assign bad = (req_rect_type != TYPE_FILLED && req_rect_type != TYPE_OUTLINE) ||
                (req_rect_width <= 0) || (req_rect_height <= 0);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(MAX_SIDE);
         height_ff <= CFG_W'(MAX_SIDE);
         bg_ff     <= BG_RESET;
      end else if (csr_valid) begin
         unique case (ridx)
            REG_WIDTH:  width_ff  <= clamp_side(csr_data);
            REG_HEIGHT: height_ff <= clamp_side(csr_data);
            REG_BG:     bg_ff     <= csr_data[CHAR_W-1:0];
            default:    ;
         endcase
      end
   end

   // sticky error flag
   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= 1'b0;
      end else if (cmd.accept) begin
         if (op == OP_CLEAR) begin
            err_ff <= 1'b0;
         end else if (op == OP_DRAW && !err_ff && bad) begin
            err_ff <= 1'b1;
         end
      end
   end

   // item latch and sweep counters
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         clear_ff    <= (op == OP_CLEAR);
         filled_ff   <= (req_rect_type == TYPE_FILLED);
         char_ff     <= (op == OP_CLEAR) ? bg_ff : req_rect_char;
         x_ff        <= sx;
         y_ff        <= sy;
         xend_ff     <= sx + sw;
         yend_ff     <= sy + sh;
         row_ff      <= '0;
         col_ff      <= '0;
         lim_row_ff  <= (op == OP_CLEAR) ? '1 : SIDE_W'(height_ff - CFG_W'(1));
         lim_col_ff  <= (op == OP_CLEAR) ? '1 : SIDE_W'(width_ff - CFG_W'(1));
         in_range_ff <= (CFG_W'(req_read_row) < height_ff) &&
                        (CFG_W'(req_read_col) < width_ff);
         pix_ff      <= '0;
      end else begin
         if (cmd.step) begin
            if (col_ff == lim_col_ff) begin
               col_ff <= '0;
               row_ff <= row_ff + SIDE_W'(1);
            end else begin
               col_ff <= col_ff + SIDE_W'(1);
            end
         end
         if (cmd.capture) begin
            pix_ff <= in_range_ff ? rdata : '0;
         end
      end
   end

   // pixel coverage
   assign pi = POS_W'(row_ff) << FRAC_BITS;
   assign pj = POS_W'(col_ff) << FRAC_BITS;

   assign edge_hit = (pi - y_ff < ONE) || (yend_ff - pi < ONE) ||
                     (pj - x_ff < ONE) || (xend_ff - pj < ONE);
   assign covered = (pi >= y_ff) && (pi <= yend_ff) && (pj >= x_ff) && (pj <= xend_ff) &&
                    (filled_ff || edge_hit);
   assign we = cmd.step && (clear_ff || covered);

   rrp_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(DEPTH)
   ) u_canvas (
      .clock(clock),
      .we   (we),
      .waddr({row_ff, col_ff}),
      .wdata(char_ff),
      .raddr({SIDE_W'(req_read_row), SIDE_W'(req_read_col)}),
      .rdata(rdata)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_pixel_ff     <= pix_ff;
         rsp_corrupted_ff <= err_ff;
      end
   end

   assign status.draw_go    = !err_ff && !bad;
   assign status.sweep_done = (row_ff == lim_row_ff) && (col_ff == lim_col_ff);
   assign status.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;
   assign rsp_corrupted   = rsp_corrupted_ff;

endmodule

>>> hdl/rectangle_raster_painter_top.sv
// rectangle_raster_painter_top: one word in, one word out; clear and draw sweep
// the canvas memory at one pixel per cycle (clear all 65536 pixels, draw height*width;
// a rejected draw skips the sweep); read goes through the registered memory port;
// one word in flight at a time; synchronous active-high reset clears control state and
// restores register defaults; canvas contents stay undefined until the first clear
module rectangle_raster_painter_top
   import rrp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [IDX_W-1:0]          csr_index,
   input  logic [CFG_W-1:0]          csr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_operation,
   input  logic [CHAR_W-1:0]         req_rect_type,
   input  logic signed [COORD_W-1:0] req_rect_x,
   input  logic signed [COORD_W-1:0] req_rect_y,
   input  logic signed [COORD_W-1:0] req_rect_width,
   input  logic signed [COORD_W-1:0] req_rect_height,
   input  logic [CHAR_W-1:0]         req_rect_char,
   input  logic [RC_W-1:0]           req_read_row,
   input  logic [RC_W-1:0]           req_read_col,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CHAR_W-1:0]         rsp_pixel_value,
   output logic                      rsp_corrupted
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   rrp_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_operation(req_operation),
      .status       (status),
      .cmd          (cmd),
      .req_stall    (req_stall)
   );

   rrp_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_operation  (req_operation),
      .req_rect_type  (req_rect_type),
      .req_rect_x     (req_rect_x),
      .req_rect_y     (req_rect_y),
      .req_rect_width (req_rect_width),
      .req_rect_height(req_rect_height),
      .req_rect_char  (req_rect_char),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_value(rsp_pixel_value),
      .rsp_corrupted  (rsp_corrupted)
   );

endmodule

>>> hdl/rrp_check.sv
// rrp_check: port-level assertions for the painter top level, with its bind
// depends on rrp_pkg and rectangle_raster_painter_top
module rrp_check
   import rrp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CHAR_W-1:0] rsp_pixel_value,
   input logic              rsp_corrupted
);

   // one word at a time: busy right after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again right after accept");

   // a new result only comes out of a busy cycle
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_pixel_value) && $stable(rsp_corrupted)))
      else $error("stalled result word changed");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind rectangle_raster_painter_top rrp_check u_rrp_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pixel_value(rsp_pixel_value),
   .rsp_corrupted  (rsp_corrupted)
);

>>> bench/tb_rectangle_raster_painter_top.sv
// tb_rectangle_raster_painter_top: self-checking bench for the rectangle raster painter
// keeps a shadow canvas, error flag and register copy, predicts each reply word and
// compares it field by field; depends on rrp_pkg and rectangle_raster_painter_top
module tb_rectangle_raster_painter_top;
   import rrp_pkg::*;

   localparam int     PX            = 1 << FRAC_BITS;
   localparam longint CYCLE_LIMIT   = 5_000_000;
   localparam int     RANDOM_CLEARS = 8;

   typedef struct {
      op_type                    op;
      logic [CHAR_W-1:0]         rtype;
      logic signed [COORD_W-1:0] x, y, w, h;
      logic [CHAR_W-1:0]         ch;
      logic [RC_W-1:0]           row, col;
   } paint_cmd_type;

   typedef struct {
      logic [CHAR_W-1:0] pixel;
      logic              corrupted;
   } pixel_reply_type;

   class painter_shadow;
      logic [CHAR_W-1:0] canvas_px [MAX_SIDE*MAX_SIDE];
      bit                error_seen;
      int                cols, rows;
      logic [CHAR_W-1:0] bg;
      pixel_reply_type   pending_replies [$];
      int                failures, replies_checked;

      function new();
         error_seen = 1'b0;
         cols = MAX_SIDE;
         rows = MAX_SIDE;
         bg = BG_RESET;
         failures = 0;
         replies_checked = 0;
      endfunction

      function int side_limit(logic [CFG_W-1:0] v);
         if (v == 0) return 1;
         if (int'(v) > MAX_SIDE) return MAX_SIDE;
         return int'(v);
      endfunction

      function void set_register(reg_index_type idx, logic [CFG_W-1:0] data);
         case (idx)
            REG_WIDTH:  cols = side_limit(data);
            REG_HEIGHT: rows = side_limit(data);
            REG_BG:     bg = data[CHAR_W-1:0];
            default: ;
         endcase
      endfunction

      function void paint_rect(paint_cmd_type c);
         longint one, x, y, w, h, pi, pj;
         bit     covered, near_edge;
         one = longint'(1) << FRAC_BITS;
         x = c.x;
         y = c.y;
         w = c.w;
         h = c.h;
         for (int i = 0; i < rows; i++) begin
            pi = i * one;
            for (int j = 0; j < cols; j++) begin
               pj = j * one;
               covered = pi >= y && pi <= y + h && pj >= x && pj <= x + w;
               near_edge = (pi - y < one) || (y + h - pi < one) ||
                           (pj - x < one) || (x + w - pj < one);
               if (covered && (c.rtype == TYPE_FILLED || near_edge)) begin
                  canvas_px[i*MAX_SIDE + j] = c.ch;
               end
            end
         end
      endfunction

      function void accept_command(paint_cmd_type c);
         pixel_reply_type r;
         r.pixel = '0;
         case (c.op)
            OP_CLEAR: begin
               foreach (canvas_px[k]) canvas_px[k] = bg;
               error_seen = 1'b0;
            end
            OP_DRAW: begin
               if (!error_seen) begin
                  if ((c.rtype != TYPE_FILLED && c.rtype != TYPE_OUTLINE) ||
                      c.w <= 0 || c.h <= 0) begin
                     error_seen = 1'b1;
                  end else begin
                     paint_rect(c);
                  end
               end
            end
            OP_READ: begin
               if (c.row < rows && c.col < cols) begin
                  r.pixel = canvas_px[c.row*MAX_SIDE + c.col];
               end
            end
            default: ;
         endcase
         r.corrupted = error_seen;
         pending_replies.push_back(r);
      endfunction

      function void check_pixel_reply(logic [CHAR_W-1:0] pixel, logic corrupted);
         pixel_reply_type want;
         if (pending_replies.size() == 0) begin
            $error("reply word with none expected: pixel_value %0d corrupted %0d",
                   pixel, corrupted);
            failures++;
            return;
         end
         want = pending_replies.pop_front();
         replies_checked++;
         if (pixel !== want.pixel) begin
            $error("pixel_value: expected %0d, got %0d", want.pixel, pixel);
            failures++;
         end
         if (corrupted !== want.corrupted) begin
            $error("corrupted: expected %0d, got %0d", want.corrupted, corrupted);
            failures++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [IDX_W-1:0]          csr_index;
   logic [CFG_W-1:0]          csr_data;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_operation;
   logic [CHAR_W-1:0]         req_rect_type;
   logic signed [COORD_W-1:0] req_rect_x;
   logic signed [COORD_W-1:0] req_rect_y;
   logic signed [COORD_W-1:0] req_rect_width;
   logic signed [COORD_W-1:0] req_rect_height;
   logic [CHAR_W-1:0]         req_rect_char;
   logic [RC_W-1:0]           req_read_row;
   logic [RC_W-1:0]           req_read_col;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [CHAR_W-1:0]         rsp_pixel_value;
   logic                      rsp_corrupted;

   painter_shadow shadow;
   bit            quiet = 1'b0;
   int            clear_budget;
   int            clears_issued, draws_issued, reads_issued;
   longint        cycle_count = 0;

   rectangle_raster_painter_top dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_rect_type   (req_rect_type),
      .req_rect_x      (req_rect_x),
      .req_rect_y      (req_rect_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_rect_char   (req_rect_char),
      .req_read_row    (req_read_row),
      .req_read_col    (req_read_col),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_corrupted   (rsp_corrupted)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 8);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         shadow.check_pixel_reply(rsp_pixel_value, rsp_corrupted);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout with %0d reply words outstanding", shadow.pending_replies.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic paint_cmd_type noise_cmd();
      paint_cmd_type c;
      c.op = op_type'($urandom_range(0, 3));
      c.rtype = CHAR_W'($urandom);
      c.x = COORD_W'($urandom);
      c.y = COORD_W'($urandom);
      c.w = COORD_W'($urandom);
      c.h = COORD_W'($urandom);
      c.ch = CHAR_W'($urandom);
      c.row = RC_W'($urandom);
      c.col = RC_W'($urandom);
      return c;
   endfunction

   task automatic write_register(input reg_index_type idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      shadow.set_register(idx, data);
   endtask

   task automatic configure(input int cols, input int rows, input logic [CHAR_W-1:0] bg);
      write_register(REG_WIDTH, CFG_W'(cols));
      write_register(REG_HEIGHT, CFG_W'(rows));
      write_register(REG_BG, CFG_W'(bg));
      write_register(REG_UNUSED, CFG_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic send_command(input paint_cmd_type c);
      while (!quiet && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= c.op;
      req_rect_type <= c.rtype;
      req_rect_x <= c.x;
      req_rect_y <= c.y;
      req_rect_width <= c.w;
      req_rect_height <= c.h;
      req_rect_char <= c.ch;
      req_read_row <= c.row;
      req_read_col <= c.col;
      do @(posedge clock); while (!(req_valid && !req_stall));
      shadow.accept_command(c);
      case (c.op)
         OP_CLEAR: clears_issued++;
         OP_DRAW:  draws_issued++;
         OP_READ:  reads_issued++;
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (shadow.pending_replies.size() != 0);
   endtask

   task automatic do_clear();
      paint_cmd_type c;
      c = noise_cmd();
      c.op = OP_CLEAR;
      send_command(c);
   endtask

   task automatic do_idle_op();
      paint_cmd_type c;
      c = noise_cmd();
      c.op = OP_NONE;
      send_command(c);
   endtask

   task automatic do_read(input int row, input int col);
      paint_cmd_type c;
      c = noise_cmd();
      c.op = OP_READ;
      c.row = RC_W'(row);
      c.col = RC_W'(col);
      send_command(c);
   endtask

   task automatic do_draw(input logic [CHAR_W-1:0] t, input int x, input int y,
                          input int w, input int h, input logic [CHAR_W-1:0] ch);
      paint_cmd_type c;
      c = noise_cmd();
      c.op = OP_DRAW;
      c.rtype = t;
      c.x = COORD_W'(x);
      c.y = COORD_W'(y);
      c.w = COORD_W'(w);
      c.h = COORD_W'(h);
      c.ch = ch;
      send_command(c);
   endtask

   task automatic random_phase(input int n);
      paint_cmd_type c;
      int            counted;
      int            pick;
      counted = 0;
      while (counted < n) begin
         c = noise_cmd();
         pick = $urandom_range(0, 99);
         if (clear_budget > 0 && (pick < 3 || (shadow.error_seen && pick < 40))) begin
            c.op = OP_CLEAR;
         end else if (pick < 50) begin
            // well-formed rectangle near the canvas
            c.op = OP_DRAW;
            c.rtype = $urandom_range(0, 1) ? TYPE_FILLED : TYPE_OUTLINE;
            c.x = COORD_W'(int'($urandom_range(0, (shadow.cols + 8) * PX)) - 4 * PX);
            c.y = COORD_W'(int'($urandom_range(0, (shadow.rows + 8) * PX)) - 4 * PX);
            c.w = COORD_W'($urandom_range(1,
                     ($urandom_range(0, 2) == 0 ? shadow.cols + 4 : 4) * PX));
            c.h = COORD_W'($urandom_range(1,
                     ($urandom_range(0, 2) == 0 ? shadow.rows + 4 : 4) * PX));
            if ($urandom_range(0, 9) < 4) begin
               c.x[FRAC_BITS-1:0] = '0;
               c.y[FRAC_BITS-1:0] = '0;
               c.w[FRAC_BITS-1:0] = '0;
               c.h[FRAC_BITS-1:0] = '0;
               if (c.w == 0) c.w = COORD_W'(PX);
               if (c.h == 0) c.h = COORD_W'(PX);
            end
         end else if (pick < 54) begin
            // rejected rectangle
            c.op = OP_DRAW;
            case ($urandom_range(0, 2))
               0: begin
                  if (c.rtype == TYPE_FILLED || c.rtype == TYPE_OUTLINE) c.rtype ^= 8'h01;
               end
               1: begin
                  c.rtype = TYPE_OUTLINE;
                  c.w = COORD_W'(-int'($urandom_range(0, 4 * PX)));
                  c.h = COORD_W'($urandom_range(1, 4 * PX));
               end
               default: begin
                  c.rtype = TYPE_FILLED;
                  c.w = COORD_W'($urandom_range(1, 4 * PX));
                  c.h = COORD_W'(-int'($urandom_range(0, 4 * PX)));
               end
            endcase
         end else if (pick < 94) begin
            c.op = OP_READ;
            if ($urandom_range(0, 6) != 0) begin
               c.row = RC_W'($urandom_range(0, shadow.rows < 255 ? shadow.rows : 255));
               c.col = RC_W'($urandom_range(0, shadow.cols < 255 ? shadow.cols : 255));
            end
         end else if (c.op == OP_CLEAR && clear_budget == 0) begin
            c.op = OP_NONE;
         end
         if (c.op == OP_CLEAR) clear_budget--;
         if (!(c.op == OP_NONE || (c.op == OP_DRAW && shadow.error_seen))) counted++;
         send_command(c);
      end
   endtask

   initial begin
      shadow = new();
      clear_budget = RANDOM_CLEARS;
      clears_issued = 0;
      draws_issued = 0;
      reads_issued = 0;
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= REG_WIDTH;
      csr_data <= '0;
      req_valid <= 1'b0;
      req_operation <= OP_NONE;
      req_rect_type <= '0;
      req_rect_x <= '0;
      req_rect_y <= '0;
      req_rect_width <= '0;
      req_rect_height <= '0;
      req_rect_char <= '0;
      req_read_row <= '0;
      req_read_col <= '0;
      rsp_stall <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // full 256 x 256 canvas with reset background
      do_clear();
      do_draw(TYPE_FILLED, 250 * PX, 250 * PX, 10 * PX, 10 * PX, "@");
      do_read(255, 255);
      do_read(249, 250);
      drain();

      configure(20, 16, ".");
      do_clear();
      do_read(0, 0);
      do_draw(TYPE_FILLED, 2 * PX + PX / 2, PX, 5 * PX + PX / 4, 3 * PX, "#");
      do_draw(TYPE_OUTLINE, 8 * PX, 4 * PX, 6 * PX, 5 * PX, "*");
      do_draw(TYPE_OUTLINE, PX + PX / 2, 10 * PX + PX / 2, 2 * PX + PX / 2, PX + PX / 2,
              "o");
      do_draw(TYPE_FILLED, -524288, -524288, 524287, 524287, "!");
      do_draw(TYPE_OUTLINE, 0, 0, 524287, 524287, "+");
      do_draw(TYPE_OUTLINE, -8 * PX, 12 * PX, 40 * PX, 2 * PX, "=");
      do_read(2, 3);
      do_read(6, 10);
      do_read(16, 0);
      do_read(0, 20);
      do_read(255, 255);
      do_idle_op();
      do_draw(8'h00, 0, 0, PX, PX, "E");
      do_draw(TYPE_FILLED, 0, 0, 4 * PX, 4 * PX, "Z");
      do_read(1, 1);
      do_clear();
      do_draw(TYPE_FILLED, 0, 0, 0, PX, "W");
      do_clear();
      do_draw(TYPE_OUTLINE, 0, 0, PX, -524288, "H");
      drain();

      // out-of-range sizes saturate: one column, all rows
      configure(0, 511, 8'h00);
      random_phase(18);
      drain();

      configure(300, 1, 8'hFF);
      random_phase(18);
      drain();

      // no idling on either side
      configure(33, 24, "a");
      quiet = 1'b1;
      random_phase(18);
      drain();
      quiet = 1'b0;

      configure(7, 5, "x");
      random_phase(18);
      drain();
      repeat (20) @(posedge clock);

      $display("covered %0d clears, %0d draws, %0d reads on canvases from 1 to 256 wide and high",
               clears_issued, draws_issued, reads_issued);
      $display("%0d reply words checked, %0d mismatches",
               shadow.replies_checked, shadow.failures);
      if (shadow.failures == 0 && shadow.pending_replies.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
